>>> rtl/core/gfse_pkg.sv
package gfse_pkg;

   localparam int XW    = 32;
   localparam int SW    = 31;
   localparam int UW    = 17;
   localparam int ACCW  = 48;
   localparam int DW    = 33;   // x - m
   localparam int DDW   = 66;   // d*d
   localparam int SSW   = 62;   // s*s
   localparam int AW    = 20;   // exponent argument, Q.16
   localparam int EW    = 33;   // e, up to 2^32
   localparam int GW    = 17;
   localparam logic [AW-1:0] LN2_Q16 = AW'(45426);
   localparam logic [ACCW-1:0] ACC_MAX = {ACCW{1'b1}};
   localparam logic [3:0] EXP_TERMS = 4'd10;

   // csr register byte addresses
   localparam logic [2:0] ADDR_MEAN  = 3'd0;
   localparam logic [2:0] ADDR_SIGMA = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,       // serial squares of d and s
      ST_CHK,
      ST_DIV,      // restoring division, one quotient bit a cycle
      ST_RED,      // range reduction by ln2
      ST_EXP,      // Horner steps
      ST_EXPDIV,   // divide by k, one bit a cycle
      ST_G,
      ST_RES,      // residual square, serial
      ST_ACC,
      ST_OUT
   } state_type;

endpackage

>>> rtl/core/gaussian_fit_sq_error.sv
// Gaussian fit squared-error accumulator. Each req item (x, u, last) adds
// round((u - g)^2 / 2^16) to a 48-bit saturating sum, where
// g = exp(-(x-m)^2/(2 s^2)) in Q1.16; on the last item the sum and its
// saturation flag go out as one rsp item and the sum is cleared. The block
// is bit serial and takes one item at a time: two serial squares (each 33
// shift-add steps plus start and collect), a 20-bit restoring division
// (one quotient bit a cycle), a ln2 range reduction by repeated
// subtraction, ten exponential steps each with a serial multiply and a
// 36-bit serial divide by k, then a serial residual square. The ln2 count
// n is at most 23. Zero-distance and flushed points skip the division and
// the exponential. A last point also loads the output register, waiting
// while that register is still held by rsp. The csr port holds
// center_mean at byte 0 and width_sigma at byte 4; write only while idle.
module gaussian_fit_sq_error import gfse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // [31:0] sample_x, [48:32] target_u, zero pad
   input  logic        req_tlast,   // last_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [47:0] sum_sq_error
   output logic        rsp_tuser,   // saturated
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   state_type state_ff, state_in;

   logic [31:0]     mean_ff, mean_in;
   logic [SW-1:0]   sigma_ff, sigma_in;
   logic [ACCW-1:0] acc_ff, acc_in;
   logic            ovf_ff, ovf_in;
   logic [ACCW-1:0] osum_ff, osum_in;
   logic            osat_ff, osat_in;
   logic            ovld_ff, ovld_in;

   logic [UW-1:0]  u_ff, u_in;       // clamped target
   logic           last_ff, last_in;
   logic [DW-1:0]  ad_ff, ad_in;     // |x - m|
   logic [DDW-1:0] dd_ff, dd_in;
   logic [SSW-1:0] ss_ff, ss_in;
   logic [1:0]     ph_ff, ph_in;     // multiply phase
   logic [67:0]    rem_ff, rem_in;   // division remainder (also exp divide)
   logic [AW-1:0]  a_ff, a_in;       // quotient / reduced argument
   logic [4:0]     n_ff, n_in;
   logic [EW-1:0]  e_ff, e_in;
   logic [3:0]     k_ff, k_in;
   logic [6:0]     cnt_ff, cnt_in;
   logic [GW-1:0]  g_ff, g_in;

   // shared serial multiplier
   logic        m_start, m_done;
   logic [32:0] m_a, m_b;
   logic [65:0] m_p;

   gfse_serial_mul u_mul (
      .clock(clock), .reset(reset), .start(m_start),
      .a(m_a), .b(m_b), .done(m_done), .p(m_p)
   );

   logic wr;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr)
         ADDR_MEAN:  csr_prdata = mean_ff;
         ADDR_SIGMA: csr_prdata = {1'b0, sigma_ff};
         default:    csr_prdata = '0;
      endcase
   end

   logic signed [DW-1:0] d_w;
   logic [16:0]          utr;
   logic [DDW+1:0]       den_w;
   logic [67:0]          rem_sh;
   logic [67:0]          sub_w;
   logic [EW:0]          ed_sh;
   logic [40:0]          gr;
   logic [ACCW:0]        sum_w;
   logic [31:0]          q_w;
   logic [4:0]           pr_w, pt_w;   // divide-by-k partial remainder and trial

   always_comb begin
      state_in = state_ff;
      mean_in = mean_ff; sigma_in = sigma_ff;
      acc_in = acc_ff; ovf_in = ovf_ff;
      osum_in = osum_ff; osat_in = osat_ff; ovld_in = ovld_ff;
      u_in = u_ff; last_in = last_ff; ad_in = ad_ff; dd_in = dd_ff; ss_in = ss_ff;
      ph_in = ph_ff; rem_in = rem_ff; a_in = a_ff; n_in = n_ff; e_in = e_ff;
      k_in = k_ff; cnt_in = cnt_ff; g_in = g_ff;
      m_start = 1'b0; m_a = ad_ff; m_b = ad_ff;
      d_w = $signed({req_tdata[31], req_tdata[31:0]}) - $signed({mean_ff[31], mean_ff});
      utr = (req_tdata[48:32] > 17'd65536) ? 17'd65536 : req_tdata[48:32];
      den_w = {5'd0, ss_ff, 1'b0};
      rem_sh = {rem_ff[66:0], 1'b0};
      sub_w = rem_sh - den_w[67:0];
      ed_sh = '0;
      gr = '0;
      sum_w = '0;
      q_w = '0;
      pr_w = '0;
      pt_w = '0;

      if (rsp_tvalid && rsp_tready) ovld_in = 1'b0;
      if (wr && csr_paddr == ADDR_MEAN)  mean_in  = csr_pwdata;
      if (wr && csr_paddr == ADDR_SIGMA) sigma_in = csr_pwdata[SW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               u_in = utr; last_in = req_tlast;
               ad_in = d_w[DW-1] ? DW'(-d_w) : DW'(d_w);
               ph_in = 2'd0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            case (ph_ff)
               2'd0: begin
                  m_start = 1'b1; m_a = ad_ff; m_b = ad_ff; ph_in = 2'd1;
               end
               2'd1: if (m_done) begin
                  dd_in = m_p;
                  m_start = 1'b1; m_a = {2'd0, sigma_ff}; m_b = {2'd0, sigma_ff};
                  ph_in = 2'd2;
               end
               default: if (m_done) begin
                  ss_in = m_p[SSW-1:0];
                  state_in = ST_CHK;
               end
            endcase
         end
         ST_CHK: begin
            if (dd_ff == '0) begin
               g_in = 17'd65536; state_in = ST_RES; ph_in = 2'd0;
            end else if ({5'd0, dd_ff[DDW-1:5]} >= {4'd0, ss_ff}) begin
               g_in = '0; state_in = ST_RES; ph_in = 2'd0;
            end else begin
               // quotient < 16, so 4 integer + 16 fraction bits from the top
               rem_in = {2'd0, dd_ff} >> 4;
               // preload: bits below start in dd, shifted in one per cycle
               a_in = '0; cnt_in = 7'd20;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // bring in next dividend bit (bits 3..0 of dd), then zeros
            rem_sh = {rem_ff[66:0], (cnt_ff > 7'd16) ? dd_ff[cnt_ff[1:0] - 2'd1] : 1'b0};
            sub_w = rem_sh - den_w[67:0];
            if (!sub_w[67]) begin
               rem_in = sub_w; a_in = {a_ff[AW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh; a_in = {a_ff[AW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               n_in = '0; state_in = ST_RED;
            end
         end
         ST_RED: begin
            if (a_ff >= LN2_Q16) begin
               a_in = a_ff - LN2_Q16; n_in = n_ff + 5'd1;
            end else begin
               e_in = 33'h1_0000_0000; k_in = EXP_TERMS; ph_in = 2'd0;
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (ph_ff == 2'd0) begin
               m_start = 1'b1; m_a = {13'd0, a_ff}; m_b = e_ff; ph_in = 2'd1;
            end else if (m_done) begin
               // numerator floor(r*e/2^16) < 2^36: divide by k serially
               rem_in = {32'd0, m_p[51:16]};
               q_w = '0;
               a_in = a_ff; cnt_in = 7'd36; e_in = '0;
               state_in = ST_EXPDIV;
            end
         end
         ST_EXPDIV: begin
            // restoring divide by k; quotient collected in e
            ed_sh = {1'b0, e_ff} << 1;
            rem_sh = rem_ff;
            sub_w = {rem_ff[67:36], 36'd0};
            pr_w = {rem_ff[67:64], rem_ff[35]};
            pt_w = pr_w - {1'b0, k_ff};
            rem_in = {rem_ff[67:36], rem_ff[34:0], 1'b0};
            if (!pt_w[4]) begin
               rem_in[67:64] = pt_w[3:0];
               e_in = ed_sh[EW-1:0] | 33'd1;
            end else begin
               rem_in[67:64] = pr_w[3:0];
               e_in = ed_sh[EW-1:0];
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               e_in = 33'h1_0000_0000 - {e_in[EW-1:0]};
               rem_in = '0;
               if (k_ff == 4'd1) state_in = ST_G;
               else begin
                  k_in = k_ff - 4'd1; ph_in = 2'd0; state_in = ST_EXP;
               end
            end
         end
         ST_G: begin
            // shift counts reach 39, so the sum and counts are kept wide
            gr = ({8'd0, e_ff} + (41'd1 << (6'd15 + {1'b0, n_ff}))) >> (6'd16 + {1'b0, n_ff});
            g_in = gr[GW-1:0];
            ph_in = 2'd0;
            state_in = ST_RES;
         end
         ST_RES: begin
            if (ph_ff == 2'd0) begin
               m_start = 1'b1;
               m_a = (u_ff >= g_ff) ? 33'(u_ff - g_ff) : 33'(g_ff - u_ff);
               m_b = m_a;
               ph_in = 2'd1;
            end else if (m_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            q_w = 32'((m_p[34:0] + 35'd32768) >> 16);
            sum_w = {1'b0, acc_ff} + {17'd0, q_w};
            if (sum_w[ACCW]) begin
               acc_in = ACC_MAX; ovf_in = 1'b1;
            end else acc_in = sum_w[ACCW-1:0];
            if (last_ff) state_in = ST_OUT;
            else state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (!ovld_ff) begin
               osum_in = acc_ff; osat_in = ovf_ff; ovld_in = 1'b1;
               acc_in = '0; ovf_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mean_ff  <= '0;
         sigma_ff <= SW'(65536);
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         ovld_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         mean_ff  <= mean_in;
         sigma_ff <= sigma_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         ovld_ff  <= ovld_in;
      end
      osum_ff <= osum_in; osat_ff <= osat_in;
      u_ff <= u_in; last_ff <= last_in; ad_ff <= ad_in; dd_ff <= dd_in; ss_ff <= ss_in;
      ph_ff <= ph_in; rem_ff <= rem_in; a_ff <= a_in; n_ff <= n_in; e_ff <= e_in;
      k_ff <= k_in; cnt_ff <= cnt_in; g_ff <= g_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = osum_ff;
   assign rsp_tuser  = osat_ff;
endmodule

>>> rtl/core/gfse_serial_mul.sv
// Shift-add multiplier: one multiplier bit per cycle.
module gfse_serial_mul import gfse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [32:0]      a,
   input  logic [32:0]      b,
   output logic             done,
   output logic [65:0]      p
);
   logic [65:0] acc_ff, acc_in;
   logic [65:0] mc_ff, mc_in;
   logic [32:0] mp_ff, mp_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;

   always_comb begin
      acc_in = acc_ff; mc_in = mc_ff; mp_in = mp_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         acc_in = '0; mc_in = {33'd0, a}; mp_in = b; cnt_in = 6'd33; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in = {mc_ff[64:0], 1'b0};
         mp_in = {1'b0, mp_ff[32:1]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
   end

   // product valid whenever no multiply is running
   assign done = !busy_ff;
   assign p    = acc_ff;
endmodule

>>> tb/sv/gfse_checker.sv
`timescale 1ns / 1ps

// Watches the csr, req and rsp channels; predicts each sum and compares.
module gfse_checker import gfse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          sums_pending
);

   typedef struct packed {
      logic [ACCW-1:0] total;
      logic            clipped;
   } fit_sum_type;

   logic signed [XW-1:0] model_mean;
   logic [SW-1:0]        model_sigma;
   logic [ACCW-1:0]      model_acc;
   logic                 model_clip;
   fit_sum_type          sums_due[$];

   // Q1.16 Gaussian value at x for center m and width s
   function automatic logic [63:0] gauss_value(logic [31:0] x, logic [31:0] m,
                                               logic [30:0] s);
      logic signed [32:0] d;
      logic [127:0] ad, dd, ss, den, a;
      logic [63:0] n, r, e;
      d  = $signed({x[31], x}) - $signed({m[31], m});
      ad = d[32] ? 128'(33'(-d)) : 128'(33'(d));
      dd = ad * ad;
      ss = 128'(s) * 128'(s);
      if (dd == 0) return 64'd65536;
      if ((dd >> 5) >= ss) return 64'd0;   // flush, also covers zero width
      den = ss << 1;
      a   = (dd << 16) / den;
      n   = 64'(a) / 64'(LN2_Q16);
      r   = 64'(a) - n * 64'(LN2_Q16);
      e   = 64'd1 << 32;
      for (int k = 10; k >= 1; k--) begin
         e = (64'd1 << 32) - (((r * e) >> 16) / 64'(k));
      end
      return (e + (64'd1 << (15 + n))) >> (16 + n);
   endfunction

   task automatic report(string what);
      $display("%0t ERROR %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [63:0] g, u, diff, sq;
      fit_sum_type want;
      if (reset) begin
         model_mean  <= '0;
         model_sigma <= SW'(65536);
         model_acc   <= '0;
         model_clip  <= 1'b0;
         fail_count  = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_MEAN)  model_mean  <= csr_pwdata;
            if (csr_paddr == ADDR_SIGMA) model_sigma <= csr_pwdata[SW-1:0];
         end
         if (req_tvalid && req_tready) begin
            g = gauss_value(req_tdata[31:0], model_mean, model_sigma);
            u = 64'(req_tdata[48:32]);
            if (u > 64'd65536) u = 64'd65536;   // target above one clips
            diff = (u >= g) ? u - g : g - u;
            sq   = (diff * diff + 64'd32768) >> 16;
            want.total   = model_acc;
            want.clipped = model_clip;
            if (sq > 64'(ACC_MAX - model_acc)) begin
               want.total   = ACC_MAX;
               want.clipped = 1'b1;
            end else begin
               want.total = model_acc + ACCW'(sq);
            end
            if (req_tlast) begin
               sums_due.push_back(want);
               model_acc  <= '0;
               model_clip <= 1'b0;
            end else begin
               model_acc  <= want.total;
               model_clip <= want.clipped;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (sums_due.size() == 0) begin
               report($sformatf("unexpected sum %0d", rsp_tdata));
            end else begin
               want = sums_due.pop_front();
               if (rsp_tdata !== want.total)
                  report($sformatf("sum got %0d want %0d", rsp_tdata, want.total));
               if (rsp_tuser !== want.clipped)
                  report($sformatf("clip flag got %b want %b", rsp_tuser, want.clipped));
            end
         end
      end
      sums_pending = sums_due.size();
   end

endmodule

>>> tb/sv/tb_gaussian_fit_sq_error.sv
`timescale 1ns / 1ps

module tb_gaussian_fit_sq_error;
   import gfse_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // [31:0] sample_x, [48:32] target_u, zero pad
   logic        req_tlast = 1'b0; // last_point
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [47:0] sum_sq_error
   logic        rsp_tuser;        // saturated
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          sums_pending;
   int          sums_seen = 0;

   logic [31:0] cur_mean;
   logic [30:0] cur_sigma;

   always #1 clock = ~clock;

   gaussian_fit_sq_error u_dut (.*);

   gfse_checker u_chk (.*);

   // gap length: mostly none or short, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(30, 200);
   endfunction

   // the block only takes one item at a time, so the sender holds each point until ready
   task automatic send_point(logic [31:0] x, logic [16:0] u, logic last);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, u, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // drain: last sum back, then let a trailing item finish
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (sums_pending == 0);
      repeat (1200) @(posedge clock);
   endtask

   task automatic set_fit(logic [31:0] mean, logic [30:0] sigma);
      drain();
      csr_write(ADDR_MEAN, mean);
      csr_write(ADDR_SIGMA, {1'b0, sigma});
      cur_mean  = mean;
      cur_sigma = sigma;
   endtask

   // x near the center most of the time so the exponential gets exercised
   function automatic logic [31:0] pick_x();
      int r;
      logic [63:0] span, off;
      r = $urandom_range(0, 99);
      if (r < 10) return cur_mean;
      if (r < 30) return $urandom;
      span = 64'(cur_sigma) * 8 + 1;
      off  = {$urandom, $urandom} % span;
      return cur_mean + 32'(off - 64'(cur_sigma) * 4);
   endfunction

   function automatic logic [16:0] pick_u();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return 17'($urandom_range(0, 65536));
      if (r < 85) return 17'd65536;
      return 17'($urandom);       // above one now and then
   endfunction

   // result side: random stalls, plus one long hold-off so the input backs up
   always @(posedge clock) begin
      int stall_left;
      int r;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sums_seen++;
         if (sums_seen == 20 && rsp_tvalid && rsp_tready) stall_left = 6000;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 8) stall_left = $urandom_range(1, 3);
            else if (r < 9) stall_left = $urandom_range(20, 300);
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   initial begin
      logic [31:0] mean;
      logic [30:0] sigma;
      int set_len;
      int sent;
      int next_fit;
      cur_mean  = '0;
      cur_sigma = 31'd65536;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset config, extremes of x and u
      send_point(32'd0, 17'd0, 1'b0);
      send_point(32'd0, 17'd65536, 1'b0);
      send_point(32'd0, 17'h1FFFF, 1'b0);
      send_point(32'h7FFFFFFF, 17'd0, 1'b0);
      send_point(32'h80000000, 17'd65535, 1'b1);
      send_point(32'h00010000, 17'd40000, 1'b1);
      send_point(32'hFFFF8000, 17'd30000, 1'b1);
      // narrowest nonzero width at the top of the range
      set_fit(32'h7FFFFFFF, 31'd1);
      send_point(32'h7FFFFFFF, 17'd65536, 1'b0);
      send_point(32'h7FFFFFFE, 17'd12345, 1'b0);
      send_point(32'h80000000, 17'd1, 1'b1);
      // zero width: only an exact hit gives one
      set_fit(32'h80000000, 31'd0);
      send_point(32'h80000000, 17'd0, 1'b0);
      send_point(32'h80000001, 17'd65536, 1'b0);
      send_point(32'h7FFFFFFF, 17'h10000, 1'b1);
      // widest
      set_fit(32'd0, 31'h7FFFFFFF);
      send_point(32'h7FFFFFFF, 17'd50000, 1'b0);
      send_point(32'h80000000, 17'd20000, 1'b0);
      send_point(32'h12345678, 17'd0, 1'b1);

      // random data sets, a new fit every 150 points or so
      sent = 0;
      next_fit = 0;
      while (sent < 1050) begin
         if (sent >= next_fit) begin
            next_fit = next_fit + 150;
            mean  = $urandom;
            sigma = 31'($urandom) >> $urandom_range(0, 30);
            if ($urandom_range(0, 19) == 0) sigma = 31'd0;
            set_fit(mean, sigma);
         end
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                : $urandom_range(1, 8);
         for (int i = 0; i < set_len; i++) begin
            send_point(pick_x(), pick_u(), i == set_len - 1);
            sent++;
         end
      end
      drain();
      if (fail_count == 0 && sums_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> gaussian_fit_sq_error.f
rtl/core/gfse_pkg.sv
rtl/core/gfse_serial_mul.sv
rtl/core/gaussian_fit_sq_error.sv
tb/sv/gfse_checker.sv
tb/sv/tb_gaussian_fit_sq_error.sv
